FILE: hdl/cbs_pkg.sv
// Package for the clocked bit sampler: constants, codes, state encoding and the
// word types shared by the front end, the queues and the execution back end.
// Depends on nothing.
package cbs_pkg;

  // Bit store geometry.
  localparam int unsigned StoreBits = 4096;
  localparam int unsigned AddrW     = $clog2(StoreBits);

  // Fixed field widths.
  localparam int unsigned SliceW = 13;
  localparam int unsigned PosW   = SliceW + 1;
  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned ReqW   = 2;

  // A slice returns at most this many bits.
  localparam int unsigned SliceMax = 32;
  localparam int unsigned CntW     = $clog2(SliceMax + 1);

  // Request codes on the input side.
  localparam logic [ReqW-1:0] ReqArm   = 2'd0;
  localparam logic [ReqW-1:0] ReqEdge  = 2'd1;
  localparam logic [ReqW-1:0] ReqSlice = 2'd2;

  // Configuration register indexes.
  localparam int unsigned     CfgIdxW         = 2;
  localparam logic [CfgIdxW-1:0] CfgBitsWanted   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMinIdle      = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSampleRising = 2'd2;

  localparam logic [CountW-1:0] BitsWantedRst = 16'd24;
  localparam logic [CountW-1:0] CountMax      = '1;

  // Depth of the queues between the parts.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    OP_ARM,
    OP_EDGE,
    OP_SLICE,
    OP_NONE
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EDGE,
    ST_SETUP,
    ST_START,
    ST_WALK,
    ST_REPORT
  } bstate_e;

  typedef struct packed {
    op_e                      op;
    logic                     edge_is_rising;
    logic                     data_bit;
    logic [TimeW-1:0]         time_now;
    logic signed [SliceW-1:0] slice_first;
    logic signed [SliceW-1:0] slice_last;
    logic                     sign_extend;
  } cmd_t;

  typedef struct packed {
    logic [ValueW-1:0] slice_value;
    logic              is_running;
    logic              is_ready;
    logic [CountW-1:0] restart_total;
    logic [CountW-1:0] sampled_total;
    logic [AddrW-1:0]  write_position;
  } res_t;

  typedef struct packed {
    logic [CountW-1:0] bits_wanted;
    logic [TimeW-1:0]  min_idle_time;
    logic              sample_on_rising;
  } cfg_t;

endpackage

FILE: hdl/clocked_bit_sampler.sv
// Clocked bit sampler top level: ports, configuration registers and the
// front end, command queue, back end and result queue. Depends on cbs_pkg.
//
// The sampler captures one data bit per selected clock edge into a circular
// 4096-bit store and reports one result word for every request word. After
// reset the store is swept to zero, one bit per cycle, so full stays high
// until the sweep is done; configuration writes are taken during that time.
// Input words go through a register and a two-entry queue to the sequencer,
// and results wait in a two-entry queue, so pushing can go on while a result
// waits to be popped. The sequencer handles one word at a time: an arm or an
// unused request code goes straight to the report state, a clock edge passes
// through the edge state, and a slice read passes the setup and start states
// and then reads n bits (at most 32) after the fill bit, one bit per cycle,
// since the store has one read port. Slice ends that are negative count back
// from the write position; a slice longer than 32 bits keeps its last 32 bits.
// Configuration is written through a separate valid/ready channel that is
// always ready; write it only while the block has no request in flight.
module clocked_bit_sampler
  import cbs_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Request side.
  input  logic                     push,
  output logic                     full,
  input  logic [ReqW-1:0]          req_type_i,
  input  logic                     edge_is_rising_i,
  input  logic                     data_bit_i,
  input  logic [TimeW-1:0]         time_now_i,
  input  logic signed [SliceW-1:0] slice_first_i,
  input  logic signed [SliceW-1:0] slice_last_i,
  input  logic                     sign_extend_i,
  // Result side.
  output logic                     empty,
  input  logic                     pop,
  output logic [ValueW-1:0]        slice_value_o,
  output logic                     is_running_o,
  output logic                     is_ready_o,
  output logic [CountW-1:0]        restart_total_o,
  output logic [CountW-1:0]        sampled_total_o,
  output logic [AddrW-1:0]         write_position_o,
  // Configuration write channel.
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [TimeW-1:0]         cfg_data_i
);

  cfg_t cfg_q;
  logic cfg_we;

  logic front_full, front_push;
  logic cmd_valid, cmd_full, cmd_empty, cmd_pop;
  cmd_t front_cmd, queue_cmd;
  logic res_push, res_full;
  res_t back_res, out_res;
  logic clearing;

  // Configuration registers; an index beyond the list is accepted and dropped.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bits_wanted      <= BitsWantedRst;
      cfg_q.min_idle_time    <= '0;
      cfg_q.sample_on_rising <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index_i)
        CfgBitsWanted:   cfg_q.bits_wanted      <= cfg_data_i[CountW-1:0];
        CfgMinIdle:      cfg_q.min_idle_time    <= cfg_data_i;
        CfgSampleRising: cfg_q.sample_on_rising <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // No word is taken while the store is being cleared.
  assign full       = front_full || clearing;
  assign front_push = push && !clearing;

  cbs_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (front_push),
    .full_o           (front_full),
    .req_type_i       (req_type_i),
    .edge_is_rising_i (edge_is_rising_i),
    .data_bit_i       (data_bit_i),
    .time_now_i       (time_now_i),
    .slice_first_i    (slice_first_i),
    .slice_last_i     (slice_last_i),
    .sign_extend_i    (sign_extend_i),
    .cmd_valid_o      (cmd_valid),
    .cmd_o            (front_cmd),
    .cmd_full_i       (cmd_full)
  );

  cbs_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_valid),
    .full_o  (cmd_full),
    .data_i  (front_cmd),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .data_o  (queue_cmd)
  );

  cbs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (queue_cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (back_res),
    .clearing_o  (clearing)
  );

  cbs_res_queue u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .full_o  (res_full),
    .data_i  (back_res),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (out_res)
  );

  assign slice_value_o    = out_res.slice_value;
  assign is_running_o     = out_res.is_running;
  assign is_ready_o       = out_res.is_ready;
  assign restart_total_o  = out_res.restart_total;
  assign sampled_total_o  = out_res.sampled_total;
  assign write_position_o = out_res.write_position;

endmodule

FILE: hdl/cbs_front.sv
// Front end of the clocked bit sampler: input word register and request decode.
// Depends on cbs_pkg.
module cbs_front
  import cbs_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  output logic                     full_o,
  input  logic [ReqW-1:0]          req_type_i,
  input  logic                     edge_is_rising_i,
  input  logic                     data_bit_i,
  input  logic [TimeW-1:0]         time_now_i,
  input  logic signed [SliceW-1:0] slice_first_i,
  input  logic signed [SliceW-1:0] slice_last_i,
  input  logic                     sign_extend_i,
  output logic                     cmd_valid_o,
  output cmd_t                     cmd_o,
  input  logic                     cmd_full_i
);

  logic vld_q, vld_d;
  cmd_t cmd_q;
  op_e  op;
  logic load, move;

  always_comb begin
    unique case (req_type_i)
      ReqArm:   op = OP_ARM;
      ReqEdge:  op = OP_EDGE;
      ReqSlice: op = OP_SLICE;
      default:  op = OP_NONE;
    endcase
  end

  assign move   = vld_q && !cmd_full_i;
  assign full_o = vld_q && cmd_full_i;
  assign load   = push_i && !full_o;
  assign vld_d  = load || (vld_q && !move);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q.op             <= op;
      cmd_q.edge_is_rising <= edge_is_rising_i;
      cmd_q.data_bit       <= data_bit_i;
      cmd_q.time_now       <= time_now_i;
      cmd_q.slice_first    <= slice_first_i;
      cmd_q.slice_last     <= slice_last_i;
      cmd_q.sign_extend    <= sign_extend_i;
    end
  end

  assign cmd_valid_o = vld_q;
  assign cmd_o       = cmd_q;

endmodule

FILE: hdl/cbs_cmd_queue.sv
// Short command queue between the front end and the back end.
// Depends on cbs_pkg.
module cbs_cmd_queue
  import cbs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  output logic full_o,
  input  cmd_t data_i,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t data_o
);

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

FILE: hdl/cbs_res_queue.sv
// Result queue that holds finished words until the consumer pops them.
// Depends on cbs_pkg.
module cbs_res_queue
  import cbs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  output logic full_o,
  input  res_t data_i,
  input  logic pop_i,
  output logic empty_o,
  output res_t data_o
);

  res_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

FILE: hdl/cbs_back.sv
// Back end of the clocked bit sampler: capture state, bit store memory and the
// sequencer that carries out arm, edge and slice commands. Depends on cbs_pkg.
module cbs_back
  import cbs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic cmd_empty_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  input  logic res_full_i,
  output logic res_push_o,
  output res_t res_o,
  output logic clearing_o
);

  bstate_e state_q, state_d;

  // Capture state.
  logic [AddrW-1:0]  wp_q;
  logic [CountW-1:0] sampled_q;
  logic [CountW-1:0] restart_q;
  logic [TimeW-1:0]  edge_time_q;
  logic              running_q;
  logic              ready_q;

  // Work registers.
  logic [AddrW-1:0]       clr_q;
  cmd_t                   cmd_q;
  logic                   edge_ok_q;
  logic                   gap_gt_q;
  logic                   pkt_full_q;
  logic signed [PosW-1:0] first_q, last_q;
  logic                   up_q;
  logic [PosW-1:0]        diff_q;
  logic [AddrW-1:0]       pos_q;
  logic [CntW-1:0]        cnt_q;
  logic                   rd_vld_q;
  logic                   ext_done_q;
  logic [ValueW-1:0]      acc_q;

  // Bit store.
  logic             mem_q [StoreBits];
  logic             rd_data_q;
  logic             mem_we, wr_data, rd_en;
  logic [AddrW-1:0] wr_addr, rd_addr;

  // Slice end resolution and walk setup.
  logic signed [PosW-1:0] first_ext, last_ext, first_res, last_res;
  logic [PosW-1:0]        wp_ext;
  logic [TimeW-1:0]       gap;
  logic                   long_slice;
  logic [PosW-1:0]        off;
  logic [AddrW-1:0]       first_lo;

  assign wp_ext    = {{(PosW - AddrW){1'b0}}, wp_q};
  assign first_ext = {cmd_i.slice_first[SliceW-1], cmd_i.slice_first};
  assign last_ext  = {cmd_i.slice_last[SliceW-1], cmd_i.slice_last};
  assign first_res = cmd_i.slice_first[SliceW-1] ? first_ext + $signed(wp_ext) : first_ext;
  assign last_res  = cmd_i.slice_last[SliceW-1] ? last_ext + $signed(wp_ext) : last_ext;
  assign gap       = cmd_i.time_now - edge_time_q;

  assign long_slice = (diff_q >= PosW'(SliceMax));
  assign off        = diff_q - PosW'(SliceMax - 1);
  assign first_lo   = first_q[AddrW-1:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == '1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          unique case (cmd_i.op)
            OP_EDGE:  state_d = ST_EDGE;
            OP_SLICE: state_d = ST_SETUP;
            default:  state_d = ST_REPORT;
          endcase
        end
      end
      ST_EDGE:  state_d = ST_REPORT;
      ST_SETUP: state_d = ST_START;
      ST_START: state_d = ST_WALK;
      ST_WALK: begin
        if (cnt_q == '0 && !rd_vld_q) state_d = ST_REPORT;
      end
      ST_REPORT: begin
        if (!res_full_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    clearing_o = 1'b0;
    mem_we     = 1'b0;
    wr_addr    = gap_gt_q ? '0 : wp_q;
    wr_data    = cmd_q.data_bit;
    rd_en      = 1'b0;
    rd_addr    = pos_q;
    unique case (state_q)
      ST_CLEAR: begin
        clearing_o = 1'b1;
        mem_we     = 1'b1;
        wr_addr    = clr_q;
        wr_data    = 1'b0;
      end
      ST_IDLE:   cmd_pop_o = !cmd_empty_i;
      ST_EDGE:   mem_we = edge_ok_q && !(gap_gt_q && pkt_full_q);
      ST_START: begin
        rd_en   = 1'b1;
        rd_addr = first_lo;
      end
      ST_WALK:   rd_en = (cnt_q != '0);
      ST_REPORT: res_push_o = !res_full_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[wr_addr] <= wr_data;
    if (rd_en)  rd_data_q <= mem_q[rd_addr];
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      wp_q        <= '0;
      sampled_q   <= '0;
      restart_q   <= '0;
      edge_time_q <= '0;
      running_q   <= 1'b0;
      ready_q     <= 1'b0;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      ext_done_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_en;
      unique case (state_q)
        ST_CLEAR: clr_q <= clr_q + 1'b1;
        ST_IDLE: begin
          if (!cmd_empty_i && cmd_i.op == OP_ARM) begin
            wp_q        <= '0;
            sampled_q   <= '0;
            restart_q   <= '0;
            running_q   <= 1'b1;
            ready_q     <= 1'b0;
            edge_time_q <= cmd_i.time_now;
          end
        end
        ST_EDGE: begin
          if (edge_ok_q) begin
            if (gap_gt_q && pkt_full_q) begin
              running_q <= 1'b0;
              ready_q   <= 1'b1;
            end else begin
              if (gap_gt_q && restart_q != CountMax) restart_q <= restart_q + 1'b1;
              wp_q      <= (gap_gt_q ? '0 : wp_q) + 1'b1;
              sampled_q <= sampled_q + 1'b1;
            end
            edge_time_q <= cmd_q.time_now;
          end
        end
        ST_START: begin
          cnt_q      <= long_slice ? CntW'(SliceMax) : diff_q[CntW-1:0] + CntW'(1);
          ext_done_q <= 1'b0;
        end
        ST_WALK: begin
          if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
          if (rd_vld_q)    ext_done_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_q      <= cmd_i;
          acc_q      <= '0;
          edge_ok_q  <= running_q && !ready_q &&
                        (cmd_i.edge_is_rising == cfg_i.sample_on_rising);
          gap_gt_q   <= (gap > cfg_i.min_idle_time);
          pkt_full_q <= (sampled_q >= cfg_i.bits_wanted);
          first_q    <= first_res;
          last_q     <= last_res;
        end
      end
      ST_SETUP: begin
        up_q   <= (first_q < last_q);
        diff_q <= (first_q < last_q) ? PosW'(last_q - first_q) : PosW'(first_q - last_q);
      end
      ST_START: begin
        if (!long_slice) begin
          pos_q <= first_lo;
        end else if (up_q) begin
          pos_q <= first_lo + off[AddrW-1:0];
        end else begin
          pos_q <= first_lo - off[AddrW-1:0];
        end
      end
      ST_WALK: begin
        if (cnt_q != '0) pos_q <= up_q ? pos_q + 1'b1 : pos_q - 1'b1;
        if (rd_vld_q) begin
          if (!ext_done_q) begin
            // The first read returns the bit at the first position, which only
            // decides the fill of the upper bits.
            acc_q <= (cmd_q.sign_extend && rd_data_q) ? '1 : '0;
          end else begin
            acc_q <= {acc_q[ValueW-2:0], rd_data_q};
          end
        end
      end
      default: ;
    endcase
  end

  assign res_o.slice_value    = acc_q;
  assign res_o.is_running     = running_q;
  assign res_o.is_ready       = ready_q;
  assign res_o.restart_total  = restart_q;
  assign res_o.sampled_total  = sampled_q;
  assign res_o.write_position = wp_q;

  a_store_write_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_CLEAR || state_q == ST_EDGE))
    else $error("bit store written outside the clearing pass or an edge");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(running_q && ready_q))
    else $error("capture is running and ready at once");

  a_read_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == ST_WALK))
    else $error("store read data arrived outside a slice walk");

  a_pop_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> (state_q != ST_IDLE))
    else $error("command taken without leaving idle");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(SliceMax))
    else $error("slice walk longer than the result word");

endmodule
